// File: rtl/normalized_distance_ranged_macros.svh
// Assertion helpers used by normalized_distance_ranged.sv.
`ifndef NORMALIZED_DISTANCE_RANGED_MACROS_SVH
`define NORMALIZED_DISTANCE_RANGED_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ND_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Check that a condition implies a consequence on the same edge.
`define ND_ASSERT_IMPL(label, cond, cons, msg) \
    `ND_ASSERT(label, (cond) |-> (cons), msg)

`endif

// File: rtl/nd_pkg.sv
package nd_pkg;

    localparam int unsigned RES_W   = 16;
    localparam int unsigned FRAME_W = 16;
    localparam int unsigned TS_W    = 32;
    localparam int unsigned TIME_W  = 48;

    localparam logic [1:0] REG_RANGE_BEGIN = 2'd0;
    localparam logic [1:0] REG_RANGE_TOP   = 2'd1;
    localparam logic [1:0] REG_TIME_SCALE  = 2'd2;

    localparam logic signed [RES_W-1:0] RANGE_BEGIN_RST = 16'sh8000;
    localparam logic signed [RES_W-1:0] RANGE_TOP_RST   = 16'sh7FFF;
    localparam logic [TS_W-1:0]         TIME_SCALE_RST  = 32'h0001_0000;

    // Fields that ride along with an item through the pipeline.
    typedef struct packed {
        logic signed [RES_W-1:0] residue;
        logic [TIME_W-1:0]       stime;
        logic                    inr;
        logic                    degen;
        logic                    fend;
    } t_side;

endpackage

// File: rtl/nd_divsqrt.sv
module nd_divsqrt #(
    parameter int unsigned DW = 70,
    parameter int unsigned F  = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_ce,
    input  logic            i_valid,
    input  logic [DW-1:0]   i_a,
    input  logic [DW-1:0]   i_d,
    input  nd_pkg::t_side   i_side,
    output logic            o_valid,
    output nd_pkg::t_side   o_side,
    output logic [F:0]      o_frac,
    output logic [F:0]      o_nd
);

    localparam int unsigned RW = DW + 1;
    localparam int unsigned NW = 2 * F + 2;

    // Restoring divider, one quotient bit per stage.
    logic [RW-1:0]  r_rem  [0:F];
    logic [DW-1:0]  r_d    [0:F];
    logic [F:0]     r_q    [0:F];
    nd_pkg::t_side  r_dside[0:F];
    logic           r_dv   [0:F];

    // Digit-by-digit square root, one result bit per stage.
    logic [NW-1:0]  r_srem [0:F];
    logic [F:0]     r_root [0:F];
    logic [F:0]     r_frac [0:F];
    nd_pkg::t_side  r_sside[0:F];
    logic           r_sv   [0:F];

    genvar k;
    generate
        for (k = 0; k <= F; k++) begin : g_div
            logic [RW-1:0] rem_in;
            logic [DW-1:0] d_in;
            logic [F:0]    q_in;
            nd_pkg::t_side side_in;
            logic          v_in;
            logic          ge;
            logic [RW-1:0] rem_sub;
            logic [RW-1:0] n_rem;

            if (k == 0) begin : g_first
                assign rem_in  = RW'(i_a);
                assign d_in    = i_d;
                assign q_in    = '0;
                assign side_in = i_side;
                assign v_in    = i_valid;
            end else begin : g_next
                assign rem_in  = r_rem[k-1];
                assign d_in    = r_d[k-1];
                assign q_in    = r_q[k-1];
                assign side_in = r_dside[k-1];
                assign v_in    = r_dv[k-1];
            end

            assign ge      = rem_in >= RW'(d_in);
            assign rem_sub = ge ? (rem_in - RW'(d_in)) : rem_in;
            if (k < F) begin : g_shift
                assign n_rem = {rem_sub[RW-2:0], 1'b0};
            end else begin : g_last
                assign n_rem = rem_sub;
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_dv[k] <= 1'b0;
                end else if (i_ce) begin
                    r_dv[k] <= v_in;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_ce) begin
                    r_rem[k]   <= n_rem;
                    r_d[k]     <= d_in;
                    r_q[k]     <= {q_in[F-1:0], ge};
                    r_dside[k] <= side_in;
                end
            end
        end

        for (k = 0; k <= F; k++) begin : g_sqrt
            localparam int unsigned B = F - k;
            logic [NW-1:0] rem_in;
            logic [F:0]    root_in;
            logic [F:0]    frac_in;
            nd_pkg::t_side side_in;
            logic          v_in;
            logic [NW-1:0] trial;
            logic          ge;

            if (k == 0) begin : g_first
                // Out of range or zero denominator: force the quotient to zero.
                assign frac_in = (r_dside[F].degen || !r_dside[F].inr) ? '0 : r_q[F];
                assign rem_in  = NW'({frac_in, {F{1'b0}}});
                assign root_in = '0;
                assign side_in = r_dside[F];
                assign v_in    = r_dv[F];
            end else begin : g_next
                assign frac_in = r_frac[k-1];
                assign rem_in  = r_srem[k-1];
                assign root_in = r_root[k-1];
                assign side_in = r_sside[k-1];
                assign v_in    = r_sv[k-1];
            end

            // (r + 2^b)^2 - r^2 = r * 2^(b+1) + 2^(2b)
            assign trial = (NW'(root_in) << (B + 1)) + (NW'(1) << (2 * B));
            assign ge    = rem_in >= trial;

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_sv[k] <= 1'b0;
                end else if (i_ce) begin
                    r_sv[k] <= v_in;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_ce) begin
                    r_srem[k]  <= ge ? (rem_in - trial) : rem_in;
                    r_root[k]  <= ge ? (root_in | ((F+1)'(1) << B)) : root_in;
                    r_frac[k]  <= frac_in;
                    r_sside[k] <= side_in;
                end
            end
        end
    endgenerate

    assign o_valid = r_sv[F];
    assign o_side  = r_sside[F];
    assign o_frac  = r_frac[F];
    assign o_nd    = r_root[F];

endmodule

// File: rtl/normalized_distance_ranged.sv
// Normalized distance along a transition, one residue per transfer. The block takes a new
// residue every clock cycle unless a finished result is held by an output stall. The
// pipeline has three front stages for differences, squares and sums, then one stage per
// quotient bit of the divider and one per bit of the square root. A stall on the output
// while a result is waiting freezes the whole pipeline and is passed straight back to the
// input. Residues outside [range_begin, range_top] still give a result, with in_range clear
// and zero distance fields; coincident points inside the range give degenerate.
`include "normalized_distance_ranged_macros.svh"

module normalized_distance_ranged #(
    parameter int unsigned COORD_WIDTH      = 24,
    parameter int unsigned RESULT_FRAC_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [1:0]                    i_cfg_index,
    input  logic [31:0]                   i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [15:0]            i_residue_number,
    input  logic signed [COORD_WIDTH-1:0] i_begin_x,
    input  logic signed [COORD_WIDTH-1:0] i_begin_y,
    input  logic signed [COORD_WIDTH-1:0] i_begin_z,
    input  logic signed [COORD_WIDTH-1:0] i_current_x,
    input  logic signed [COORD_WIDTH-1:0] i_current_y,
    input  logic signed [COORD_WIDTH-1:0] i_current_z,
    input  logic signed [COORD_WIDTH-1:0] i_end_x,
    input  logic signed [COORD_WIDTH-1:0] i_end_y,
    input  logic signed [COORD_WIDTH-1:0] i_end_z,
    input  logic [15:0]                   i_frame_number,
    input  logic                          i_last_of_frame,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [15:0]            o_residue_out,
    output logic [47:0]                   o_scaled_time,
    output logic                          o_in_range,
    output logic [RESULT_FRAC_BITS:0]     o_fraction,
    output logic [RESULT_FRAC_BITS:0]     o_normalized_distance,
    output logic                          o_degenerate,
    output logic                          o_frame_end
);

    localparam int unsigned F   = RESULT_FRAC_BITS;
    localparam int unsigned DFW = COORD_WIDTH + 1;
    localparam int unsigned SQW = 2 * DFW;
    localparam int unsigned AW  = SQW + 2;
    localparam int unsigned DW  = SQW + 3;

    logic signed [15:0] r_range_begin;
    logic signed [15:0] r_range_top;
    logic [31:0]        r_time_scale;

    logic signed [DFW-1:0] r_s1_diff [0:5];
    nd_pkg::t_side         r_s1_side;
    logic                  r_s1_v;
    logic [SQW-1:0]        r_s2_sq [0:5];
    nd_pkg::t_side         r_s2_side;
    logic                  r_s2_v;
    logic [DW-1:0]         r_s3_a;
    logic [DW-1:0]         r_s3_d;
    nd_pkg::t_side         r_s3_side;
    logic                  r_s3_v;

    logic                  ce;
    logic                  ds_valid;
    nd_pkg::t_side         ds_side;
    logic signed [DFW-1:0] diff [0:5];
    nd_pkg::t_side         s1_side;
    nd_pkg::t_side         s3_side;
    logic [AW-1:0]         sum_a;
    logic [AW-1:0]         sum_b;
    logic [DW-1:0]         sum_d;

    // Advance everything unless a finished result is held by the stall.
    assign ce      = !(ds_valid && i_stall);
    assign o_stall = !ce;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range_begin <= nd_pkg::RANGE_BEGIN_RST;
            r_range_top   <= nd_pkg::RANGE_TOP_RST;
            r_time_scale  <= nd_pkg::TIME_SCALE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                nd_pkg::REG_RANGE_BEGIN: r_range_begin <= i_cfg_data[15:0];
                nd_pkg::REG_RANGE_TOP:   r_range_top   <= i_cfg_data[15:0];
                nd_pkg::REG_TIME_SCALE:  r_time_scale  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        diff[0] = DFW'(i_begin_x)   - DFW'(i_current_x);
        diff[1] = DFW'(i_begin_y)   - DFW'(i_current_y);
        diff[2] = DFW'(i_begin_z)   - DFW'(i_current_z);
        diff[3] = DFW'(i_current_x) - DFW'(i_end_x);
        diff[4] = DFW'(i_current_y) - DFW'(i_end_y);
        diff[5] = DFW'(i_current_z) - DFW'(i_end_z);
        s1_side.residue = i_residue_number;
        s1_side.stime   = 48'(i_frame_number) * 48'(r_time_scale);
        s1_side.inr     = (i_residue_number >= r_range_begin)
                       && (i_residue_number <= r_range_top);
        s1_side.degen   = 1'b0;
        s1_side.fend    = i_last_of_frame;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
        end else if (ce) begin
            r_s1_v <= i_valid;
            r_s2_v <= r_s1_v;
            r_s3_v <= r_s2_v;
        end
    end

    genvar j;
    generate
        for (j = 0; j < 6; j++) begin : g_sq
            logic [DFW-1:0] mag;
            assign mag = r_s1_diff[j][DFW-1] ? DFW'(-r_s1_diff[j]) : DFW'(r_s1_diff[j]);
            always_ff @(posedge i_clk) begin
                if (ce) begin
                    r_s1_diff[j] <= diff[j];
                    r_s2_sq[j]   <= SQW'(mag) * SQW'(mag);
                end
            end
        end
    endgenerate

    assign sum_a = AW'(r_s2_sq[0]) + AW'(r_s2_sq[1]) + AW'(r_s2_sq[2]);
    assign sum_b = AW'(r_s2_sq[3]) + AW'(r_s2_sq[4]) + AW'(r_s2_sq[5]);
    assign sum_d = DW'(sum_a) + DW'(sum_b);

    always_comb begin
        s3_side       = r_s2_side;
        s3_side.degen = r_s2_side.inr && (sum_d == '0);
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_s1_side <= s1_side;
            r_s2_side <= r_s1_side;
            r_s3_a    <= DW'(sum_a);
            r_s3_d    <= sum_d;
            r_s3_side <= s3_side;
        end
    end

    nd_divsqrt #(
        .DW (DW),
        .F  (F)
    ) u_divsqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_valid (r_s3_v),
        .i_a     (r_s3_a),
        .i_d     (r_s3_d),
        .i_side  (r_s3_side),
        .o_valid (ds_valid),
        .o_side  (ds_side),
        .o_frac  (o_fraction),
        .o_nd    (o_normalized_distance)
    );

    assign o_valid       = ds_valid;
    assign o_residue_out = ds_side.residue;
    assign o_scaled_time = ds_side.stime;
    assign o_in_range    = ds_side.inr;
    assign o_degenerate  = ds_side.degen;
    assign o_frame_end   = ds_side.fend;

    `ND_ASSERT_IMPL(a_degen_zero, o_valid && o_degenerate,
        o_fraction == '0 && o_normalized_distance == '0, "degenerate result not zero")
    `ND_ASSERT_IMPL(a_out_of_range, o_valid && !o_in_range,
        !o_degenerate && o_fraction == '0, "out-of-range result not cleared")
    `ND_ASSERT_IMPL(a_frac_bound, o_valid,
        o_fraction <= ((F+1)'(1) << F), "fraction above one")
    `ND_ASSERT_IMPL(a_root_ge_frac, o_valid,
        o_normalized_distance >= o_fraction, "root below fraction")

endmodule

// File: sim/tb.sv
`timescale 1ns / 100ps

module tb;

    localparam int CW          = 24;
    localparam int FB          = 16;
    localparam int LATENCY     = 2 * FB + 5;
    localparam int IDLE_LIMIT  = 5000;
    localparam int RAND_PHASES = 6;
    localparam int PHASE_ITEMS = 280;
    localparam logic [1:0] REG_UNUSED = 2'd3;

    typedef struct {
        logic signed [15:0]   res;
        logic signed [CW-1:0] crd [9];   // begin xyz, current xyz, end xyz
        logic [15:0]          frame;
        logic                 last;
    } t_residue;

    typedef struct {
        logic signed [15:0] res;
        logic [47:0]        stime;
        logic               inr;
        logic [FB:0]        frac;
        logic [FB:0]        nd;
        logic               degen;
        logic               fend;
    } t_distance;

    typedef struct {
        t_residue    it;
        logic        typed;          // distance fields given by hand
        logic        e_inr;
        logic [FB:0] e_frac;
        logic [FB:0] e_nd;
        logic        e_degen;
        logic        narrow_first;   // narrow the range before this row
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [1:0] i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;
    logic i_valid = 1'b0;
    logic o_stall;
    logic signed [15:0] i_residue_number = '0;
    logic signed [CW-1:0] i_begin_x = '0, i_begin_y = '0, i_begin_z = '0;
    logic signed [CW-1:0] i_current_x = '0, i_current_y = '0, i_current_z = '0;
    logic signed [CW-1:0] i_end_x = '0, i_end_y = '0, i_end_z = '0;
    logic [15:0] i_frame_number = '0;
    logic i_last_of_frame = 1'b0;
    logic o_valid;
    logic i_stall = 1'b0;
    logic signed [15:0] o_residue_out;
    logic [47:0] o_scaled_time;
    logic o_in_range;
    logic [FB:0] o_fraction;
    logic [FB:0] o_normalized_distance;
    logic o_degenerate;
    logic o_frame_end;

    normalized_distance_ranged #(.COORD_WIDTH(CW), .RESULT_FRAC_BITS(FB)) dut (.*);

    always #10 i_clk = ~i_clk;

    logic signed [15:0] range_lo = nd_pkg::RANGE_BEGIN_RST;
    logic signed [15:0] range_hi = nd_pkg::RANGE_TOP_RST;
    logic [31:0]        tscale   = nd_pkg::TIME_SCALE_RST;

    t_distance pending_q [$];
    int errors = 0;
    int n_sent = 0;
    int n_recv = 0;
    int n_inr = 0;
    int n_degen = 0;
    int idle_cnt = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    function automatic t_distance predict_distance(t_residue it);
        t_distance r;
        logic [127:0] a, b, d, q;
        logic signed [CW:0] df;
        logic [CW:0] mag;
        logic [63:0] sq, cand, root;
        r.res   = it.res;
        r.stime = 48'(it.frame) * 48'(tscale);
        r.fend  = it.last;
        r.inr   = (it.res >= range_lo) && (it.res <= range_hi);
        r.frac  = '0;
        r.nd    = '0;
        r.degen = 1'b0;
        if (r.inr) begin
            a = '0;
            b = '0;
            for (int i = 0; i < 3; i++) begin
                df  = (CW+1)'(it.crd[i]) - (CW+1)'(it.crd[3+i]);
                mag = df < 0 ? -df : df;
                a   = a + 128'(mag) * 128'(mag);
                df  = (CW+1)'(it.crd[3+i]) - (CW+1)'(it.crd[6+i]);
                mag = df < 0 ? -df : df;
                b   = b + 128'(mag) * 128'(mag);
            end
            d = a + b;
            if (d == 0) begin
                r.degen = 1'b1;
            end else begin
                q      = (a << FB) / d;
                r.frac = q[FB:0];
                sq     = 64'(r.frac) << FB;
                root   = '0;
                for (int k = FB; k >= 0; k--) begin
                    cand = root | (64'd1 << k);
                    if (cand * cand <= sq) root = cand;
                end
                r.nd = root[FB:0];
            end
        end
        return r;
    endfunction

    function automatic t_residue make_residue(logic signed [15:0] res,
                                              int bx, int by, int bz,
                                              int cx, int cy, int cz,
                                              int ex, int ey, int ez,
                                              logic [15:0] frame, logic last);
        t_residue it;
        it.res = res;
        it.crd[0] = CW'(bx); it.crd[1] = CW'(by); it.crd[2] = CW'(bz);
        it.crd[3] = CW'(cx); it.crd[4] = CW'(cy); it.crd[5] = CW'(cz);
        it.crd[6] = CW'(ex); it.crd[7] = CW'(ey); it.crd[8] = CW'(ez);
        it.frame = frame;
        it.last  = last;
        return it;
    endfunction

    function automatic t_residue random_residue();
        t_residue it;
        int kind;
        logic signed [CW-1:0] base;
        kind = $urandom_range(99);
        if ($urandom_range(1))
            it.res = 16'($urandom);
        else
            it.res = ($urandom_range(1) ? range_lo : range_hi) + 16'($urandom_range(4)) - 16'sd2;
        base = CW'($urandom);
        for (int i = 0; i < 9; i++) begin
            if (kind < 45)
                it.crd[i] = CW'($urandom);
            else if (kind < 85)
                it.crd[i] = base + CW'($urandom_range(8191)) - CW'(4096);
            else
                it.crd[i] = base;
        end
        // put the current point on one of the ends now and then
        if (kind >= 85 && kind < 95) begin
            for (int i = 0; i < 3; i++)
                it.crd[($urandom_range(1) ? 0 : 6) + i] = CW'($urandom);
        end
        it.frame = $urandom_range(3) == 0 ? 16'hFFFF : 16'($urandom);
        it.last  = $urandom_range(7) == 0;
        return it;
    endfunction

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            nd_pkg::REG_RANGE_BEGIN: range_lo = val[15:0];
            nd_pkg::REG_RANGE_TOP:   range_hi = val[15:0];
            nd_pkg::REG_TIME_SCALE:  tscale   = val;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 8) @(posedge i_clk);
    endtask

    task automatic send_residue(t_residue it, t_distance expd);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid          <= 1'b1;
        i_residue_number <= it.res;
        i_begin_x   <= it.crd[0]; i_begin_y   <= it.crd[1]; i_begin_z   <= it.crd[2];
        i_current_x <= it.crd[3]; i_current_y <= it.crd[4]; i_current_z <= it.crd[5];
        i_end_x     <= it.crd[6]; i_end_y     <= it.crd[7]; i_end_z     <= it.crd[8];
        i_frame_number  <= it.frame;
        i_last_of_frame <= it.last;
        do @(posedge i_clk); while (o_stall);
        pending_q.push_back(expd);
        n_sent++;
    endtask

    // result side: compare, stall at random, watch for a hang
    always @(posedge i_clk) begin
        t_distance e;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                n_recv++;
                if (pending_q.size() == 0) begin
                    errors++;
                    if (errors <= 10) $display("unexpected transfer: residue %0d", o_residue_out);
                end else begin
                    e = pending_q.pop_front();
                    if (e.inr) n_inr++;
                    if (e.degen) n_degen++;
                    if (o_residue_out !== e.res || o_scaled_time !== e.stime ||
                        o_in_range !== e.inr || o_fraction !== e.frac ||
                        o_normalized_distance !== e.nd || o_degenerate !== e.degen ||
                        o_frame_end !== e.fend) begin
                        errors++;
                        if (errors <= 10) begin
                            $display("mismatch: exp res %0d t %0d inr %b frac %0d nd %0d dg %b fe %b",
                                     e.res, e.stime, e.inr, e.frac, e.nd, e.degen, e.fend);
                            $display("          got res %0d t %0d inr %b frac %0d nd %0d dg %b fe %b",
                                     o_residue_out, o_scaled_time, o_in_range, o_fraction,
                                     o_normalized_distance, o_degenerate, o_frame_end);
                        end
                    end
                end
            end
            if ((i_valid && !o_stall) || (o_valid && !i_stall))
                idle_cnt <= 0;
            else
                idle_cnt <= idle_cnt + 1;
            if (idle_cnt >= IDLE_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
        i_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    initial begin
        t_row rows [$];
        t_row rw;
        t_distance e;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed rows under reset settings
        rw = '{default: '0};
        rw.typed = 1'b1; rw.e_inr = 1'b1; rw.e_degen = 1'b1;          // all points coincide
        rw.it = make_residue(0, 0,0,0, 0,0,0, 0,0,0, 0, 1'b0); rows.push_back(rw);
        rw = '{default: '0};
        rw.typed = 1'b1; rw.e_inr = 1'b1;                              // current at beginning
        rw.it = make_residue(1, 7,-3,9, 7,-3,9, 8,-3,9, 1, 1'b0); rows.push_back(rw);
        rw.e_frac = 17'h10000; rw.e_nd = 17'h10000;                    // current at end
        rw.it = make_residue(2, 0,0,0, 5,5,5, 5,5,5, 2, 1'b1); rows.push_back(rw);
        rw.it = make_residue(3, 8388607,8388607,8388607, -8388608,-8388608,-8388608,
                             -8388608,-8388608,-8388608, 65535, 1'b1);
        rows.push_back(rw);
        rw.e_frac = 17'd32768; rw.e_nd = 17'd46340;                    // midway, extremes
        rw.it = make_residue(-32768, -8388608,-8388608,-8388608, 8388607,8388607,8388607,
                             -8388608,-8388608,-8388608, 65535, 1'b0);
        rows.push_back(rw);
        rw = '{default: '0};
        rw.it = make_residue(32767, 1024,-2048,300, 4096,77,-5000, -8,9,10, 12345, 1'b1);
        rows.push_back(rw);
        rw.it = make_residue(-1, -8388608,0,8388607, 1,2,3, 8388607,0,-8388608, 0, 1'b0);
        rows.push_back(rw);
        rw.it = make_residue(100, 3072,0,0, 0,0,0, 0,4096,0, 9, 1'b1);
        rows.push_back(rw);
        // single residue range: edges of the range
        rw = '{default: '0};
        rw.narrow_first = 1'b1; rw.typed = 1'b1;
        rw.it = make_residue(4, 1,2,3, 4,5,6, 7,8,9, 3, 1'b0); rows.push_back(rw);
        rw = '{default: '0};
        rw.it = make_residue(5, 1,2,3, 4,5,6, 7,8,9, 3, 1'b0); rows.push_back(rw);
        rw.typed = 1'b1;
        rw.it = make_residue(6, 1,2,3, 4,5,6, 7,8,9, 3, 1'b1); rows.push_back(rw);

        foreach (rows[i]) begin
            if (rows[i].narrow_first) begin
                wait_drained();
                write_reg(REG_UNUSED, 32'hFFFF_FFFF);   // must be dropped
                write_reg(nd_pkg::REG_RANGE_BEGIN, 32'd5);
                write_reg(nd_pkg::REG_RANGE_TOP, 32'd5);
            end
            e = predict_distance(rows[i].it);
            if (rows[i].typed) begin
                e.inr = rows[i].e_inr; e.frac = rows[i].e_frac;
                e.nd = rows[i].e_nd; e.degen = rows[i].e_degen;
            end
            send_residue(rows[i].it, e);
        end

        for (int p = 0; p < RAND_PHASES; p++) begin
            wait_drained();
            case (p)
                0: begin write_reg(nd_pkg::REG_RANGE_BEGIN, 32'hFFFF_8000);
                         write_reg(nd_pkg::REG_RANGE_TOP, 32'h0000_7FFF);
                         write_reg(nd_pkg::REG_TIME_SCALE, 32'hFFFF_FFFF); end
                1: begin write_reg(nd_pkg::REG_RANGE_BEGIN, 32'h0000_7FFF);   // empty range
                         write_reg(nd_pkg::REG_RANGE_TOP, 32'hFFFF_8000);
                         write_reg(nd_pkg::REG_TIME_SCALE, 32'd0); end
                2: begin write_reg(nd_pkg::REG_RANGE_BEGIN, 32'hFFFF_FC00);
                         write_reg(nd_pkg::REG_RANGE_TOP, 32'd1000);
                         write_reg(nd_pkg::REG_TIME_SCALE, $urandom); end
                3: begin write_reg(nd_pkg::REG_RANGE_BEGIN, 32'h0000_7FFF);
                         write_reg(nd_pkg::REG_RANGE_TOP, 32'h0000_7FFF);
                         write_reg(nd_pkg::REG_TIME_SCALE, 32'd1); end
                4: begin write_reg(nd_pkg::REG_RANGE_BEGIN, 32'hFFFF_8000);
                         write_reg(nd_pkg::REG_RANGE_TOP, 32'hFFFF_8000);
                         write_reg(nd_pkg::REG_TIME_SCALE, 32'h0001_0000); end
                default: begin
                         write_reg(nd_pkg::REG_RANGE_BEGIN,
                                   {16'h0, 16'($urandom)} | 32'h8000_0000);
                         write_reg(nd_pkg::REG_RANGE_TOP, 32'd32000);
                         write_reg(nd_pkg::REG_TIME_SCALE, $urandom); end
            endcase
            case (p % 3)
                0: begin send_idle_pct = 9;  recv_idle_pct = 81; end
                1: begin send_idle_pct = 81; recv_idle_pct = 9;  end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                t_residue it;
                it = random_residue();
                send_residue(it, predict_distance(it));
            end
        end

        wait_drained();
        if (pending_q.size() != 0) errors++;
        $display("%0d residues sent, %0d results checked (%0d in range, %0d degenerate)",
                 n_sent, n_recv, n_inr, n_degen);
        $display("six register settings incl. empty and single-residue ranges, %0d errors",
                 errors);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl
rtl/nd_pkg.sv
rtl/nd_divsqrt.sv
rtl/normalized_distance_ranged.sv
sim/tb.sv
